### sv/hpq_pkg.sv
// Shared types, constants and control encodings for the min-heap priority queue.
package hpq_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 9;
	localparam int DEPTH = 256;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] entry_key;
		logic [TAG_W-1:0] entry_tag;
	} cmd_t;

	typedef struct packed {
		logic             out_valid;
		logic [KEY_W-1:0] out_key;
		logic [TAG_W-1:0] out_tag;
		status_t          status;
		logic [CNT_W-1:0] occupancy;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		SP_IDLE,
		SP_DECODE,
		SP_UP_CHK,
		SP_UP_TOP,
		SP_UP_CMP,
		SP_UP_PLACE,
		SP_POP_CHK,
		SP_POP_RD,
		SP_POP_GRAB,
		SP_DN_RD,
		SP_DN_CMP,
		SP_DN_PLACE,
		SP_FLAG,
		SP_FINISH
	} step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_PARENT,
		OP_UP_CMP,
		OP_PLACE_INS,
		OP_RD_ROOT,
		OP_GRAB,
		OP_RD_CHILD,
		OP_DN_CMP,
		OP_PLACE,
		OP_FLAG,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		J_NEVER,
		J_ALWAYS,
		J_ACCEPT,
		J_POP,
		J_FULL,
		J_EMPTY,
		J_ROOT,
		J_LESS_UP,
		J_NO_CHILD,
		J_LESS_DN,
		J_OUT_FREE
	} jcond_t;

	typedef struct packed {
		op_t    op;
		jcond_t jc;
		logic   hold;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic at_root;
		logic less_up;
		logic no_child;
		logic less_dn;
		logic out_free;
	} flags_t;

endpackage

### sv/hpq_ram.sv
// Generic RAM: one write port, two registered read ports.
module hpq_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### sv/hpq_datapath.sv
// Heap datapath: entry store, moving entry, position and count registers, result register.
module hpq_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  hpq_pkg::cmd_t  cmd,
	input  hpq_pkg::ctrl_t ctrl,
	output hpq_pkg::flags_t flags,
	output logic           res_valid,
	input  logic           res_stall,
	output hpq_pkg::res_t  res
);

	localparam int IW = hpq_pkg::IDX_W;
	localparam int CW = hpq_pkg::CNT_W;

	logic                  act_q;
	hpq_pkg::entry_t       mov_q;
	logic [IW-1:0]         pos_q;
	logic [CW-1:0]         count_q;
	logic [hpq_pkg::KEY_W-1:0] okey_q;
	logic [hpq_pkg::TAG_W-1:0] otag_q;
	logic                  ovalid_q;
	hpq_pkg::status_t      status_q;
	hpq_pkg::res_t         res_q;
	logic                  res_valid_q;

	logic [IW+1:0]         left;
	logic [IW+1:0]         right;
	logic [IW-1:0]         parent;
	logic [CW-1:0]         last;
	logic                  right_ok;
	logic                  pick_b;
	hpq_pkg::entry_t       pick;
	logic [IW-1:0]         pick_idx;
	logic                  less_up;
	logic                  less_dn;
	logic                  out_free;

	logic                  we;
	logic [IW-1:0]         waddr;
	hpq_pkg::entry_t       wdata;
	logic [IW-1:0]         raddr_a;
	logic [IW-1:0]         raddr_b;
	logic [hpq_pkg::KEY_W+hpq_pkg::TAG_W-1:0] rdata_a;
	logic [hpq_pkg::KEY_W+hpq_pkg::TAG_W-1:0] rdata_b;
	hpq_pkg::entry_t       rd_a;
	hpq_pkg::entry_t       rd_b;

	hpq_ram #(
		.WIDTH(hpq_pkg::KEY_W + hpq_pkg::TAG_W),
		.DEPTH(hpq_pkg::DEPTH)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign rd_a = hpq_pkg::entry_t'(rdata_a);
	assign rd_b = hpq_pkg::entry_t'(rdata_b);

	assign left     = {1'b0, pos_q, 1'b1};
	assign right    = left + (IW+2)'(1);
	assign parent   = (pos_q - IW'(1)) >> 1;
	assign last     = count_q - CW'(1);
	assign right_ok = right < {1'b0, count_q};
	assign pick_b   = right_ok && (rd_b.key < rd_a.key);
	assign pick     = pick_b ? rd_b : rd_a;
	assign pick_idx = pick_b ? right[IW-1:0] : left[IW-1:0];
	assign less_up  = mov_q.key < rd_a.key;
	assign less_dn  = pick.key < mov_q.key;
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		flags.is_pop   = act_q;
		flags.full     = count_q == CW'(hpq_pkg::DEPTH);
		flags.empty    = count_q == '0;
		flags.at_root  = pos_q == '0;
		flags.less_up  = less_up;
		flags.no_child = left >= {1'b0, count_q};
		flags.less_dn  = less_dn;
		flags.out_free = out_free;
	end

	always_comb begin
		raddr_a = parent;
		raddr_b = last[IW-1:0];
		case (ctrl.op)
			hpq_pkg::OP_RD_ROOT: begin
				raddr_a = '0;
				raddr_b = last[IW-1:0];
			end
			hpq_pkg::OP_RD_CHILD: begin
				raddr_a = left[IW-1:0];
				raddr_b = right[IW-1:0];
			end
			default: begin
				raddr_a = parent;
				raddr_b = last[IW-1:0];
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = mov_q;
		case (ctrl.op)
			hpq_pkg::OP_UP_CMP: begin
				we    = less_up;
				wdata = rd_a;
			end
			hpq_pkg::OP_DN_CMP: begin
				we    = less_dn;
				wdata = pick;
			end
			hpq_pkg::OP_PLACE_INS, hpq_pkg::OP_PLACE: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			hpq_pkg::OP_LOAD: begin
				act_q    <= cmd.action;
				mov_q    <= '{key: cmd.entry_key, tag: cmd.entry_tag};
				pos_q    <= count_q[IW-1:0];
				status_q <= hpq_pkg::ST_OK;
				okey_q   <= '0;
				otag_q   <= '0;
				ovalid_q <= 1'b0;
			end
			hpq_pkg::OP_UP_CMP: begin
				if (less_up) begin
					pos_q <= parent;
				end
			end
			hpq_pkg::OP_GRAB: begin
				okey_q   <= rd_a.key;
				otag_q   <= rd_a.tag;
				mov_q    <= rd_b;
				ovalid_q <= 1'b1;
				pos_q    <= '0;
			end
			hpq_pkg::OP_DN_CMP: begin
				if (less_dn) begin
					pos_q <= pick_idx;
				end
			end
			hpq_pkg::OP_FLAG: begin
				status_q <= act_q ? hpq_pkg::ST_EMPTY : hpq_pkg::ST_FULL;
			end
			hpq_pkg::OP_EMIT: begin
				if (out_free) begin
					res_q <= '{out_valid: ovalid_q, out_key: okey_q, out_tag: otag_q,
						status: status_q, occupancy: count_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				hpq_pkg::OP_PLACE_INS: count_q <= count_q + CW'(1);
				hpq_pkg::OP_RD_ROOT:   count_q <= last;
				default:               count_q <= count_q;
			endcase
			if (ctrl.op == hpq_pkg::OP_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### sv/hpq_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
module hpq_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  hpq_pkg::flags_t flags,
	output hpq_pkg::ctrl_t  ctrl
);

	hpq_pkg::step_t step_q;
	hpq_pkg::step_t step_nxt;
	logic           accept;
	logic           take;

	function automatic hpq_pkg::ctrl_t cw(hpq_pkg::op_t op, hpq_pkg::jcond_t jc,
		logic hold, hpq_pkg::step_t target);
		hpq_pkg::ctrl_t w;
		w.op     = op;
		w.jc     = jc;
		w.hold   = hold;
		w.target = target;
		return w;
	endfunction

	function automatic hpq_pkg::ctrl_t ucode(hpq_pkg::step_t s);
		hpq_pkg::ctrl_t w;
		case (s)
			hpq_pkg::SP_IDLE:
				w = cw(hpq_pkg::OP_LOAD, hpq_pkg::J_ACCEPT, 1'b1, hpq_pkg::SP_DECODE);
			hpq_pkg::SP_DECODE:
				w = cw(hpq_pkg::OP_NONE, hpq_pkg::J_POP, 1'b0, hpq_pkg::SP_POP_CHK);
			hpq_pkg::SP_UP_CHK:
				w = cw(hpq_pkg::OP_NONE, hpq_pkg::J_FULL, 1'b0, hpq_pkg::SP_FLAG);
			hpq_pkg::SP_UP_TOP:
				w = cw(hpq_pkg::OP_RD_PARENT, hpq_pkg::J_ROOT, 1'b0, hpq_pkg::SP_UP_PLACE);
			hpq_pkg::SP_UP_CMP:
				w = cw(hpq_pkg::OP_UP_CMP, hpq_pkg::J_LESS_UP, 1'b0, hpq_pkg::SP_UP_TOP);
			hpq_pkg::SP_UP_PLACE:
				w = cw(hpq_pkg::OP_PLACE_INS, hpq_pkg::J_ALWAYS, 1'b0, hpq_pkg::SP_FINISH);
			hpq_pkg::SP_POP_CHK:
				w = cw(hpq_pkg::OP_NONE, hpq_pkg::J_EMPTY, 1'b0, hpq_pkg::SP_FLAG);
			hpq_pkg::SP_POP_RD:
				w = cw(hpq_pkg::OP_RD_ROOT, hpq_pkg::J_NEVER, 1'b0, hpq_pkg::SP_IDLE);
			hpq_pkg::SP_POP_GRAB:
				w = cw(hpq_pkg::OP_GRAB, hpq_pkg::J_NEVER, 1'b0, hpq_pkg::SP_IDLE);
			hpq_pkg::SP_DN_RD:
				w = cw(hpq_pkg::OP_RD_CHILD, hpq_pkg::J_NO_CHILD, 1'b0, hpq_pkg::SP_DN_PLACE);
			hpq_pkg::SP_DN_CMP:
				w = cw(hpq_pkg::OP_DN_CMP, hpq_pkg::J_LESS_DN, 1'b0, hpq_pkg::SP_DN_RD);
			hpq_pkg::SP_DN_PLACE:
				w = cw(hpq_pkg::OP_PLACE, hpq_pkg::J_ALWAYS, 1'b0, hpq_pkg::SP_FINISH);
			hpq_pkg::SP_FLAG:
				w = cw(hpq_pkg::OP_FLAG, hpq_pkg::J_NEVER, 1'b0, hpq_pkg::SP_IDLE);
			hpq_pkg::SP_FINISH:
				w = cw(hpq_pkg::OP_EMIT, hpq_pkg::J_OUT_FREE, 1'b1, hpq_pkg::SP_IDLE);
			default:
				w = cw(hpq_pkg::OP_NONE, hpq_pkg::J_ALWAYS, 1'b0, hpq_pkg::SP_IDLE);
		endcase
		return w;
	endfunction

	assign accept = cmd_valid && (step_q == hpq_pkg::SP_IDLE);

	always_comb begin
		ctrl      = ucode(step_q);
		cmd_stall = step_q != hpq_pkg::SP_IDLE;
	end

	always_comb begin
		hpq_pkg::ctrl_t w;
		w = ucode(step_q);
		case (w.jc)
			hpq_pkg::J_NEVER:    take = 1'b0;
			hpq_pkg::J_ALWAYS:   take = 1'b1;
			hpq_pkg::J_ACCEPT:   take = accept;
			hpq_pkg::J_POP:      take = flags.is_pop;
			hpq_pkg::J_FULL:     take = flags.full;
			hpq_pkg::J_EMPTY:    take = flags.empty;
			hpq_pkg::J_ROOT:     take = flags.at_root;
			hpq_pkg::J_LESS_UP:  take = flags.less_up;
			hpq_pkg::J_NO_CHILD: take = flags.no_child;
			hpq_pkg::J_LESS_DN:  take = flags.less_dn;
			hpq_pkg::J_OUT_FREE: take = flags.out_free;
			default:             take = 1'b0;
		endcase
		if (take) begin
			step_nxt = w.target;
		end else if (w.hold) begin
			step_nxt = step_q;
		end else begin
			step_nxt = hpq_pkg::step_t'(4'(step_q + 4'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hpq_pkg::SP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

### sv/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue.
// One transaction at a time; a new command is taken while the previous result waits.
// Insert: the entry moves up L levels, L = 0..8, until the root or a parent not larger.
// Pop: the last entry moves down L levels, L = 0..7, until a leaf or no smaller child.
// Each level costs a registered read of the entry store and a compare with write-back.
// Reset clears the entry count and the result valid flag; the entry store is not cleared.
module min_heap_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  hpq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output hpq_pkg::res_t res
);

	hpq_pkg::ctrl_t  ctrl;
	hpq_pkg::flags_t flags;

	hpq_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.flags(flags),
		.ctrl(ctrl)
	);

	hpq_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.ctrl(ctrl),
		.flags(flags),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

endmodule
